>>> hdl/gpfpd_pkg.sv
// Shared types, character constants and helper functions for the GPFPD
// sentence checker and field splitter. No dependencies.
package gpfpd_pkg;

  // Characters that steer the scan
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  localparam int HDR_LEN = 6;

  // Role of one byte within the sentence
  typedef enum logic [2:0] {
    ROLE_DATA   = 3'd0,
    ROLE_COMMA  = 3'd1,
    ROLE_STATUS = 3'd2,
    ROLE_CKSUM  = 3'd3,
    ROLE_TERM   = 3'd4,
    ROLE_BEYOND = 3'd5
  } role_t;

  // Tag given to each byte by the field tagger
  typedef struct packed {
    logic [3:0] field_index;
    role_t      byte_role;
  } tag_t;

  // Checksum and header verdict for each byte
  typedef struct packed {
    logic       header_ok;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
  } verdict_t;

  // Decoded hex digit: valid flag and value
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Expected header character at a given position, "$GPFPD".
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h46;  // F
      3'd4:    c = 8'h50;  // P
      3'd5:    c = 8'h44;  // D
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Uppercase hex digit decode.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'h41 + 8'd10);
    end
    return h;
  endfunction

endpackage

>>> hdl/gpfpd_if.sv
// Valid/ready channel interfaces for the GPFPD sentence checker.
// No dependencies.
interface gpfpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gpfpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [3:0] field_index;
  logic [2:0] byte_role;
  logic       frame_done;
  logic       header_ok;
  logic       checksum_ok;
  logic [7:0] computed_checksum;

  modport source (output valid, output echo_byte, output field_index, output byte_role,
                  output frame_done, output header_ok, output checksum_ok,
                  output computed_checksum, input ready);
  modport sink   (input valid, input echo_byte, input field_index, input byte_role,
                  input frame_done, input header_ok, input checksum_ok,
                  input computed_checksum, output ready);
endinterface

>>> hdl/gpfpd_tagger.sv
// Field tagger: counts commas and gives each byte its field index and role.
// Depends on gpfpd_pkg.
module gpfpd_tagger #(
  parameter int FIELD_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output gpfpd_pkg::tag_t     tag
);

  localparam int CW = $clog2(FIELD_COUNT + 1);

  logic [CW-1:0] comma_count_r, comma_count_nxt;
  logic [2:0]    offset_r, offset_nxt;
  gpfpd_pkg::role_t role;

  always_comb begin
    comma_count_nxt = comma_count_r;
    offset_nxt      = offset_r;
    if (data_byte == gpfpd_pkg::CHAR_COMMA) begin
      role = gpfpd_pkg::ROLE_COMMA;
      if (comma_count_r < CW'(FIELD_COUNT)) comma_count_nxt = comma_count_r + 1'b1;
    end else if (comma_count_r < CW'(FIELD_COUNT - 1)) begin
      role = gpfpd_pkg::ROLE_DATA;
    end else if (comma_count_r == CW'(FIELD_COUNT - 1)) begin
      if (offset_r < 3'd2)      role = gpfpd_pkg::ROLE_STATUS;
      else if (offset_r < 3'd5) role = gpfpd_pkg::ROLE_CKSUM;
      else                      role = gpfpd_pkg::ROLE_TERM;
      if (offset_r < 3'd5) offset_nxt = offset_r + 3'd1;
    end else begin
      role = gpfpd_pkg::ROLE_BEYOND;
    end
    // The next frame starts from a clean count.
    if (last_byte) begin
      comma_count_nxt = '0;
      offset_nxt      = 3'd0;
    end
  end

  assign tag.field_index = (comma_count_r > 15) ? 4'd15 : 4'(comma_count_r);
  assign tag.byte_role   = role;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_count_r <= '0;
      offset_r      <= 3'd0;
    end else if (step) begin
      comma_count_r <= comma_count_nxt;
      offset_r      <= offset_nxt;
    end
  end

endmodule

>>> hdl/gpfpd_checksum.sv
// Checksum and header checker: running XOR between '$' and '*', received
// hex digits after '*', and the "$GPFPD" header match. Depends on gpfpd_pkg.
module gpfpd_checksum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output gpfpd_pkg::verdict_t verdict
);

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_BODY = 2'd1,
    SCAN_TAIL = 2'd2
  } scan_t;

  scan_t      mode_r, mode_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       hdr_match_r, hdr_match_nxt;
  logic [7:0] digits_r, digits_nxt;
  logic [1:0] dcount_r, dcount_nxt;
  logic       dvalid_r, dvalid_nxt;
  gpfpd_pkg::hex_t hex;

  assign hex = gpfpd_pkg::hex_decode(data_byte);

  always_comb begin
    mode_nxt      = mode_r;
    xor_nxt       = xor_r;
    pos_nxt       = pos_r;
    hdr_match_nxt = hdr_match_r;
    digits_nxt    = digits_r;
    dcount_nxt    = dcount_r;
    dvalid_nxt    = dvalid_r;

    if (pos_r < 3'(gpfpd_pkg::HDR_LEN)) begin
      if (data_byte != gpfpd_pkg::hdr_char(pos_r)) hdr_match_nxt = 1'b0;
      pos_nxt = pos_r + 3'd1;
    end

    case (mode_r)
      SCAN_IDLE: begin
        if (data_byte == gpfpd_pkg::CHAR_DOLLAR) mode_nxt = SCAN_BODY;
      end
      SCAN_BODY: begin
        if (data_byte == gpfpd_pkg::CHAR_STAR) mode_nxt = SCAN_TAIL;
        else if (!last_byte)                   xor_nxt  = xor_r ^ data_byte;
      end
      default: begin
        if (!last_byte) begin
          if (dcount_r < 2'd2) begin
            if (!hex.valid) dvalid_nxt = 1'b0;
            else            digits_nxt = {digits_r[3:0], hex.value};
            dcount_nxt = dcount_r + 2'd1;
          end else if (dcount_r == 2'd2) begin
            dcount_nxt = 2'd3;
          end else begin
            dvalid_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  assign verdict.computed_checksum = xor_nxt;
  assign verdict.header_ok   = last_byte && hdr_match_nxt &&
                               (pos_nxt == 3'(gpfpd_pkg::HDR_LEN));
  assign verdict.checksum_ok = last_byte && (mode_nxt == SCAN_TAIL) &&
                               (dcount_nxt == 2'd3) && dvalid_nxt &&
                               (digits_nxt == xor_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      mode_r      <= SCAN_IDLE;
      xor_r       <= 8'd0;
      pos_r       <= 3'd0;
      hdr_match_r <= 1'b1;
      digits_r    <= 8'd0;
      dcount_r    <= 2'd0;
      dvalid_r    <= 1'b1;
    end else if (step) begin
      mode_r      <= mode_nxt;
      xor_r       <= xor_nxt;
      pos_r       <= pos_nxt;
      hdr_match_r <= hdr_match_nxt;
      digits_r    <= digits_nxt;
      dcount_r    <= dcount_nxt;
      dvalid_r    <= dvalid_nxt;
    end
  end

endmodule

>>> hdl/gpfpd_sentence_checker_splitter.sv
// Top level of the GPFPD sentence checker and field splitter.
// Depends on gpfpd_pkg, gpfpd_if, gpfpd_tagger and gpfpd_checksum.
//
// Usage: the in_ch channel takes one received sentence character per item,
// with last_byte set on the closing line feed. For every input item exactly
// one item leaves on out_ch: the character echoed, its comma-counted field
// index, its role within the sentence and, on the last byte, the verdict on
// the "$GPFPD" header and on the two hex checksum digits after '*'. The
// running XOR is shown on every item.
// From acceptance to out_ch.valid, the input register takes the item and the result register
// is then loaded from it through the tagging and checksum logic.
// Throughput is one item per cycle for as long as the receiver keeps
// out_ch.ready high. The per-sentence state (comma count, XOR, header match,
// digit capture) advances as an item moves from the input register into the
// result register, so it is updated once per item and in order.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more; in_ch.ready falls only when both are full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// sentence state to its idle values; the same state is also cleared after
// each byte flagged as last, so every frame starts fresh.
module gpfpd_sentence_checker_splitter #(
  parameter int FIELD_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gpfpd_in_if.sink    in_ch,
  gpfpd_out_if.source out_ch
);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_last_r;
  gpfpd_pkg::tag_t     out_tag_r;
  gpfpd_pkg::verdict_t out_verdict_r;

  gpfpd_pkg::tag_t     tag;
  gpfpd_pkg::verdict_t verdict;

  logic advance;
  logic in_take;

  // The item in the input register moves on when the result register is
  // empty or is being emptied in this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  gpfpd_tagger #(
    .FIELD_COUNT (FIELD_COUNT)
  ) u_tagger (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .tag       (tag)
  );

  gpfpd_checksum u_checksum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .verdict   (verdict)
  );

  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)      s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
    if (advance) begin
      out_byte_r    <= s1_byte_r;
      out_last_r    <= s1_last_r;
      out_tag_r     <= tag;
      out_verdict_r <= verdict;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.echo_byte         = out_byte_r;
  assign out_ch.field_index       = out_tag_r.field_index;
  assign out_ch.byte_role         = 3'(out_tag_r.byte_role);
  assign out_ch.frame_done        = out_last_r;
  assign out_ch.header_ok         = out_verdict_r.header_ok;
  assign out_ch.checksum_ok       = out_verdict_r.checksum_ok;
  assign out_ch.computed_checksum = out_verdict_r.computed_checksum;

endmodule

>>> verif/gpfpd_sentence_checker_splitter_tb.sv
// Self-checking testbench for the GPFPD sentence checker and field splitter.
// Depends on gpfpd_pkg, gpfpd_if and gpfpd_sentence_checker_splitter from hdl.
// Drives sentence bytes through a valid/ready channel and checks every result.
module gpfpd_sentence_checker_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default of sixteen fields, so the last field
  // is the one after the fifteenth comma.
  localparam int FIELDS = 16;

  // Cycles without any item moving on either channel before the run is
  // declared hung. Random gaps at these rates never come near it.
  localparam int HANG_LIMIT = 2000;

  localparam logic [47:0] HEADER_TEXT = "$GPFPD";
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam string FIELD_CHARS = "0123456789.-ABCDEFNSEWabcdefxyz";
  localparam string HEX_UPPER = "0123456789ABCDEF";
  localparam string HEX_LOWER = "0123456789abcdef";

  // Where the XOR scan stands within the sentence.
  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,  // waiting for the first '$'
    SCAN_BODY = 2'd1,  // accumulating until '*'
    SCAN_TAIL = 2'd2   // collecting the checksum digits
  } scan_state_t;

  // One byte offered to the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_byte_t;

  // What the block should say about one byte.
  typedef struct {
    logic [7:0]        echo_byte;
    logic [3:0]        field_index;
    gpfpd_pkg::role_t  byte_role;
    logic              frame_done;
    logic              header_ok;
    logic              checksum_ok;
    logic [7:0]        computed_checksum;
  } byte_tag_t;

  logic clk;
  logic rst_n;

  gpfpd_in_if  in_ch();
  gpfpd_out_if out_ch();

  gpfpd_sentence_checker_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be offered; the head is the one on the channel while
  // valid is high.
  rx_byte_t   tx_bytes[$];
  // Tags predicted for accepted bytes whose results have not come back yet.
  byte_tag_t  predicted_tags[$];
  // Scratch sentence assembled by the stimulus tasks.
  logic [7:0] frame_buf[$];

  int  sender_idle_pct;
  int  receiver_stall_pct;
  int  mismatch_count;
  int  result_count;
  int  quiet_cycles;
  int  bytes_queued;
  logic in_taken;

  // Sentence state of the predictor, mirroring what the block must track.
  logic [7:0]  run_xor;
  scan_state_t scan;
  logic [2:0]  header_pos;
  logic        header_good;
  int          commas;
  logic [2:0]  tail_offset;
  logic [7:0]  digit_value;
  logic [1:0]  digits_seen;
  logic        digits_good;

  always #5 clk = ~clk;

  // Every frame starts from the same idle state, as does the run.
  function automatic void clear_sentence();
    run_xor     = 8'h00;
    scan        = SCAN_IDLE;
    header_pos  = 3'd0;
    header_good = 1'b1;
    commas      = 0;
    tail_offset = 3'd0;
    digit_value = 8'h00;
    digits_seen = 2'd0;
    digits_good = 1'b1;
  endfunction

  // Works out the tag for one accepted byte and advances the sentence state.
  function automatic byte_tag_t tag_and_check(input logic [7:0] b, input logic last);
    byte_tag_t  t;
    logic [7:0] want_char;
    logic       is_hex;
    logic [3:0] nibble;
    t.echo_byte   = b;
    t.field_index = (commas > 15) ? 4'd15 : 4'(commas);
    t.frame_done  = last;
    t.header_ok   = 1'b0;
    t.checksum_ok = 1'b0;

    // The header is compared byte by byte over the first six bytes only.
    if (header_pos < 3'(gpfpd_pkg::HDR_LEN)) begin
      want_char = HEADER_TEXT[8 * (5 - header_pos) +: 8];
      if (b != want_char) header_good = 1'b0;
      header_pos = header_pos + 3'd1;
    end

    // Field splitting: commas count up to the field limit; the last field
    // splits into status, checksum part and terminator by offset.
    if (b == gpfpd_pkg::CHAR_COMMA) begin
      t.byte_role = gpfpd_pkg::ROLE_COMMA;
      if (commas < FIELDS) commas++;
    end else if (commas < FIELDS - 1) begin
      t.byte_role = gpfpd_pkg::ROLE_DATA;
    end else if (commas == FIELDS - 1) begin
      if (tail_offset < 3'd2)      t.byte_role = gpfpd_pkg::ROLE_STATUS;
      else if (tail_offset < 3'd5) t.byte_role = gpfpd_pkg::ROLE_CKSUM;
      else                         t.byte_role = gpfpd_pkg::ROLE_TERM;
      if (tail_offset < 3'd5) tail_offset = tail_offset + 3'd1;
    end else begin
      t.byte_role = gpfpd_pkg::ROLE_BEYOND;
    end

    // XOR scan. A star seen before any dollar does nothing, and the last
    // byte never enters the XOR or the digit capture.
    case (scan)
      SCAN_IDLE: begin
        if (b == gpfpd_pkg::CHAR_DOLLAR) scan = SCAN_BODY;
      end
      SCAN_BODY: begin
        if (b == gpfpd_pkg::CHAR_STAR) scan = SCAN_TAIL;
        else if (!last)                run_xor = run_xor ^ b;
      end
      default: begin
        if (!last) begin
          if (digits_seen < 2'd2) begin
            is_hex = 1'b1;
            nibble = 4'd0;
            if (b >= "0" && b <= "9")      nibble = 4'(b - "0");
            else if (b >= "A" && b <= "F") nibble = 4'(b - "A" + 8'd10);
            else                           is_hex = 1'b0;
            if (is_hex) digit_value = {digit_value[3:0], nibble};
            else        digits_good = 1'b0;
            digits_seen = digits_seen + 2'd1;
          end else if (digits_seen == 2'd2) begin
            // The carriage return: counted, not checked.
            digits_seen = 2'd3;
          end else begin
            digits_good = 1'b0;
          end
        end
      end
    endcase

    t.computed_checksum = run_xor;
    if (last) begin
      t.header_ok   = header_good && (header_pos == 3'(gpfpd_pkg::HDR_LEN));
      t.checksum_ok = (scan == SCAN_TAIL) && (digits_seen == 2'd3) && digits_good &&
                      (digit_value == run_xor);
      clear_sentence();
    end
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH on result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Acceptance, prediction and checking share one clocked block, so an
  // expectation is always queued before the result it belongs to is checked.
  always @(posedge clk) begin
    byte_tag_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      clear_sentence();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        predicted_tags.push_back(tag_and_check(in_ch.data_byte, in_ch.last_byte));
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_tags.size() == 0) begin
          report_mismatch("result with nothing outstanding, echo_byte", out_ch.echo_byte, 0);
        end else begin
          want = predicted_tags.pop_front();
          if (out_ch.echo_byte !== want.echo_byte)
            report_mismatch("echo_byte", out_ch.echo_byte, want.echo_byte);
          if (out_ch.field_index !== want.field_index)
            report_mismatch("field_index", out_ch.field_index, want.field_index);
          if (out_ch.byte_role !== want.byte_role)
            report_mismatch("byte_role", out_ch.byte_role, want.byte_role);
          if (out_ch.frame_done !== want.frame_done)
            report_mismatch("frame_done", out_ch.frame_done, want.frame_done);
          if (out_ch.header_ok !== want.header_ok)
            report_mismatch("header_ok", out_ch.header_ok, want.header_ok);
          if (out_ch.checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", out_ch.checksum_ok, want.checksum_ok);
          if (out_ch.computed_checksum !== want.computed_checksum)
            report_mismatch("computed_checksum", out_ch.computed_checksum,
                            want.computed_checksum);
        end
        result_count++;
      end
    end
  end

  // Byte driver. Once valid is up it stays up with the same byte until that
  // byte is taken; otherwise each cycle may start an idle gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) void'(tx_bytes.pop_front());
      if (in_ch.valid && !in_taken) begin
        // Still waiting for the block to take the current byte.
      end else if (tx_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= tx_bytes[0].data;
        in_ch.last_byte <= tx_bytes[0].last;
      end else begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        in_ch.last_byte <= 1'($urandom);
      end
    end
  end

  // Result receiver: ready drops at random to stall the block.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Hang detection: any cycle in which nothing moves on either channel counts.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Queues the scratch sentence as input items, flagging its final byte.
  task automatic queue_frame();
    rx_byte_t item;
    for (int i = 0; i < frame_buf.size(); i++) begin
      item.data = frame_buf[i];
      item.last = (i == frame_buf.size() - 1);
      tx_bytes.push_back(item);
    end
    bytes_queued += frame_buf.size();
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  // Builds a sentence that is mostly well formed: header, commas and fields,
  // status, star, two hex digits, CR LF. A share of them carries a damaged
  // header, an odd comma count or a faulty checksum tail.
  task automatic build_sentence();
    int         n_commas;
    int         len;
    int         kind;
    logic [7:0] sum;
    frame_buf.delete();
    for (int i = 0; i < gpfpd_pkg::HDR_LEN; i++)
      frame_buf.push_back(HEADER_TEXT[8 * (5 - i) +: 8]);
    if ($urandom_range(0, 99) < 8)
      frame_buf[$urandom_range(0, gpfpd_pkg::HDR_LEN - 1)] = FIELD_CHARS[$urandom_range(0, 30)];
    n_commas = ($urandom_range(0, 99) < 80) ? FIELDS - 1 : $urandom_range(10, 20);
    for (int c = 1; c <= n_commas; c++) begin
      frame_buf.push_back(gpfpd_pkg::CHAR_COMMA);
      if (c == FIELDS - 1 && $urandom_range(0, 99) < 80) len = 2;
      else len = $urandom_range(0, 4);
      for (int k = 0; k < len; k++) frame_buf.push_back(FIELD_CHARS[$urandom_range(0, 30)]);
    end
    sum = 8'h00;
    for (int i = 1; i < frame_buf.size(); i++) sum ^= frame_buf[i];
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
      if ($urandom_range(0, 99) < 15) sum ^= 8'($urandom_range(1, 255));
      frame_buf.push_back(HEX_UPPER[sum[7:4]]);
      frame_buf.push_back(HEX_UPPER[sum[3:0]]);
    end else if (kind < 85) begin
      // Lower-case digits are not accepted as hex.
      frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
      frame_buf.push_back(HEX_LOWER[sum[7:4]]);
      frame_buf.push_back(HEX_LOWER[sum[3:0]]);
    end else if (kind < 90) begin
      frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
      frame_buf.push_back(HEX_UPPER[sum[3:0]]);
    end else if (kind < 95) begin
      frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
      frame_buf.push_back(HEX_UPPER[sum[7:4]]);
      frame_buf.push_back(HEX_UPPER[sum[3:0]]);
      frame_buf.push_back(HEX_UPPER[$urandom_range(0, 15)]);
    end
    if ($urandom_range(0, 19) != 0) frame_buf.push_back(CHAR_CR);
    frame_buf.push_back(CHAR_LF);
  endtask

  // Adds random frames until the running byte count reaches the target.
  task automatic queue_random_frames(input int target);
    int kind;
    int len;
    while (bytes_queued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_sentence();
      end else if (kind < 85) begin
        // A sentence cut short, ending on whatever byte it reached.
        build_sentence();
        len = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
      end else begin
        // Line noise over the full byte range, with some steering characters.
        frame_buf.delete();
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0:       frame_buf.push_back(gpfpd_pkg::CHAR_DOLLAR);
            1:       frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
            2:       frame_buf.push_back(gpfpd_pkg::CHAR_COMMA);
            default: frame_buf.push_back(8'($urandom));
          endcase
        end
      end
      queue_frame();
    end
  endtask

  // Holds the sender back until every queued byte is taken and every result
  // has come back.
  task automatic drain();
    while (tx_bytes.size() > 0 || in_ch.valid) @(posedge clk);
    while (predicted_tags.size() > 0) @(posedge clk);
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    result_count       = 0;
    quiet_cycles       = 0;
    bytes_queued       = 0;
    in_taken           = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames. The first has a 0xFF and a star before any dollar,
    // then a body whose XOR is below sixteen, so the digits carry a leading
    // zero.
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(gpfpd_pkg::CHAR_STAR);
    append_text("$A@*01");
    frame_buf.push_back(CHAR_CR);
    frame_buf.push_back(CHAR_LF);
    queue_frame();
    // A two-byte frame with a zero byte: header too short, no star at all.
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    frame_buf.push_back(CHAR_LF);
    queue_frame();
    // The bare header with its correct checksum.
    frame_buf.delete();
    append_text("$GPFPD*45");
    frame_buf.push_back(CHAR_CR);
    frame_buf.push_back(CHAR_LF);
    queue_frame();

    // Random traffic in four idling phases, each about a quarter of the run.
    // Between phases the sender waits until nothing is outstanding.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
      endcase
      queue_random_frames(23 + 232 * (phase + 1));
      drain();
    end

    // Let a few more cycles pass so that any stray result is caught.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/gpfpd_pkg.sv
hdl/gpfpd_if.sv
hdl/gpfpd_tagger.sv
hdl/gpfpd_checksum.sv
hdl/gpfpd_sentence_checker_splitter.sv
verif/gpfpd_sentence_checker_splitter_tb.sv
